[sv/sobel_pkg.sv]
package sobel_pkg;

   localparam int MAX_WIDTH_DEF = 2048;
   localparam int PIX_W         = 24;
   localparam int CSR_W         = 16;
   localparam int FW_W          = 12;
   localparam int FH_W          = 16;

   localparam logic [0:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [0:0] CSR_FRAME_HEIGHT = 1'b1;

   // one result slot: which mirror / centering variant of the window
   typedef struct packed {
      logic rbot;
      logic rtop;
      logic cright;
      logic cleft;
      logic fend;
   } variant_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EMIT
   } state_type;

endpackage

[sv/sobel_rgb_edge_magnitude_unit.sv]
// Streaming 3x3 Sobel edge magnitude on RGB pixels in raster order. Each
// request is one pixel; the result is the mean of the three channel
// magnitudes (each floor sqrt, saturated at 255) for the pixel one row up
// and one column left, with mirrored borders that skip the edge pixel.
// Row 0 gives no result, the last column gives an extra one, and in the
// last row each result is followed by the mirrored bottom-row result, so
// the final pixel gives four results; run_last marks the last one of a
// request and frame_end the bottom-right pixel. Two line memories hold the
// previous rows; each request reads them, writes back the shifted column,
// then emits its results one at a time through a magnitude unit that finds
// the root one bit per cycle. Requests are taken one at a time. Writing
// frame_width or frame_height restarts the frame. No clearing pass is
// needed after reset.
module sobel_rgb_edge_magnitude_unit #(
   parameter int MAX_WIDTH = sobel_pkg::MAX_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_red_in,
   input  logic [7:0]  req_green_in,
   input  logic [7:0]  req_blue_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_edge_value,
   output logic        rsp_frame_end,
   output logic        rsp_run_last,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [sobel_pkg::CSR_W-1:0] csr_data
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int CW = $clog2(MAX_WIDTH + 1);

   // configuration
   logic [sobel_pkg::FW_W-1:0] fw_ff;
   logic [sobel_pkg::FH_W-1:0] fh_ff;
   logic [CW-1:0]              w_eff;
   logic [sobel_pkg::FH_W-1:0] h_eff;

   always_comb begin
      if (int'(fw_ff) > MAX_WIDTH) begin
         w_eff = CW'(MAX_WIDTH);
      end else if (fw_ff < 12'd2) begin
         w_eff = CW'(2);
      end else begin
         w_eff = CW'(fw_ff);
      end
      h_eff = (fh_ff < 16'd2) ? 16'd2 : fh_ff;
   end

   // control state
   sobel_pkg::state_type state_ff, state_in;
   logic [CW-1:0]              col_ff;
   logic [sobel_pkg::FH_W-1:0] row_ff;
   logic [23:0]                pix_ff;
   logic [23:0]                win_ff [3][3];
   sobel_pkg::variant_type     var_ff [4];
   logic [2:0]                 nres_ff;
   logic [2:0]                 idx_ff;
   logic                       pend_ff;   // magnitude stage busy
   logic [1:0]                 pidx_ff;
   logic                       out_v_ff;
   logic [7:0]                 out_e_ff;
   logic                       out_f_ff;
   logic                       out_l_ff;

   logic [AW-1:0] addr;
   logic [23:0]   up_rd, lo_rd;
   logic          mem_we;

   assign addr   = col_ff[AW-1:0];
   assign mem_we = (state_ff == sobel_pkg::ST_READ);

   sobel_ram #(.WIDTH(sobel_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
      .clock(clock), .wr_en(mem_we), .wr_addr(addr), .wr_data(lo_rd),
      .rd_addr(addr), .rd_data(up_rd));
   sobel_ram #(.WIDTH(sobel_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_lower (
      .clock(clock), .wr_en(mem_we), .wr_addr(addr), .wr_data(pix_ff),
      .rd_addr(addr), .rd_data(lo_rd));

   // result variants for the current request
   sobel_pkg::variant_type vlist [4];
   logic [2:0] vcount;
   logic       r_top, c_left, last_row, c_last;

   always_comb begin
      r_top    = (row_ff == 16'd1);
      c_left   = (col_ff == CW'(1));
      last_row = (row_ff == h_eff - 16'd1);
      c_last   = (col_ff == w_eff - CW'(1));
      vcount   = '0;
      for (int k = 0; k < 4; k++) begin
         vlist[k] = '0;
      end
      if (row_ff != '0) begin
         if (col_ff != '0) begin
            vlist[vcount[1:0]] = '{rbot: 1'b0, rtop: r_top, cright: 1'b0,
                                   cleft: c_left, fend: 1'b0};
            vcount = vcount + 3'd1;
            if (last_row) begin
               vlist[vcount[1:0]] = '{rbot: 1'b1, rtop: 1'b0, cright: 1'b0,
                                      cleft: c_left, fend: 1'b0};
               vcount = vcount + 3'd1;
            end
         end
         if (c_last) begin
            vlist[vcount[1:0]] = '{rbot: 1'b0, rtop: r_top, cright: 1'b1,
                                   cleft: 1'b0, fend: 1'b0};
            vcount = vcount + 3'd1;
            if (last_row) begin
               vlist[vcount[1:0]] = '{rbot: 1'b1, rtop: 1'b0, cright: 1'b1,
                                      cleft: 1'b0, fend: 1'b1};
               vcount = vcount + 3'd1;
            end
         end
      end
   end

   // window tap selection for the variant being computed
   sobel_pkg::variant_type cv;
   logic [1:0] ri [3];
   logic [1:0] ci [3];
   logic [23:0] tap [3][3];

   always_comb begin
      cv = var_ff[idx_ff[1:0]];
      if (cv.rbot) begin
         ri[0] = 2'd1; ri[1] = 2'd2; ri[2] = 2'd1;
      end else begin
         ri[0] = cv.rtop ? 2'd2 : 2'd0; ri[1] = 2'd1; ri[2] = 2'd2;
      end
      if (cv.cright) begin
         ci[0] = 2'd1; ci[1] = 2'd2; ci[2] = 2'd1;
      end else begin
         ci[0] = cv.cleft ? 2'd2 : 2'd0; ci[1] = 2'd1; ci[2] = 2'd2;
      end
      for (int y = 0; y < 3; y++) begin
         for (int x = 0; x < 3; x++) begin
            tap[y][x] = win_ff[ri[y]][ci[x]];
         end
      end
   end

   // handshake
   logic out_free, issue, fin;

   logic [7:0] mag [3];
   logic       mag_rdy [3];
   for (genvar ch = 0; ch < 3; ch++) begin : g_ch
      localparam int SH = 16 - 8 * ch;
      sobel_mag u_mag (
         .clock(clock),
         .load(issue),
         .p00(tap[0][0][SH+:8]), .p01(tap[0][1][SH+:8]), .p02(tap[0][2][SH+:8]),
         .p10(tap[1][0][SH+:8]), .p12(tap[1][2][SH+:8]),
         .p20(tap[2][0][SH+:8]), .p21(tap[2][1][SH+:8]), .p22(tap[2][2][SH+:8]),
         .mag(mag[ch]),
         .ready(mag_rdy[ch]));
   end

   logic [9:0] msum;
   logic [7:0] mean;
   assign msum = 10'(mag[0]) + 10'(mag[1]) + 10'(mag[2]);
   // divide by 3 via reciprocal: (x * 683) >> 11 is exact for x < 1024
   logic [19:0] mprod;
   assign mprod = 20'(msum) * 20'd683;
   assign mean  = 8'(mprod >> 11);

   assign out_free  = !out_v_ff || !rsp_stall;
   assign req_stall = (state_ff != sobel_pkg::ST_IDLE);
   // one variant at a time: start the next once the previous result has moved out
   assign issue = (state_ff == sobel_pkg::ST_EMIT) && (idx_ff < nres_ff) && !pend_ff;
   assign fin   = pend_ff && mag_rdy[0] && mag_rdy[1] && mag_rdy[2] && out_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sobel_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = sobel_pkg::ST_READ;
            end
         end
         sobel_pkg::ST_READ: begin
            state_in = sobel_pkg::ST_EMIT;
         end
         sobel_pkg::ST_EMIT: begin
            if (idx_ff >= nres_ff && !pend_ff) begin
               state_in = sobel_pkg::ST_IDLE;
            end
         end
         default: state_in = sobel_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sobel_pkg::ST_IDLE;
         fw_ff    <= 12'd640;
         fh_ff    <= 16'd480;
         col_ff   <= '0;
         row_ff   <= '0;
         pend_ff  <= 1'b0;
         out_v_ff <= 1'b0;
         idx_ff   <= '0;
         nres_ff  <= '0;
         for (int y = 0; y < 3; y++) begin
            for (int x = 0; x < 3; x++) begin
               win_ff[y][x] <= '0;
            end
         end
      end else begin
         state_ff <= state_in;
         if (csr_write) begin
            unique case (csr_index)
               sobel_pkg::CSR_FRAME_WIDTH:  fw_ff <= csr_data[sobel_pkg::FW_W-1:0];
               sobel_pkg::CSR_FRAME_HEIGHT: fh_ff <= csr_data;
               default: ;
            endcase
            col_ff <= '0;
            row_ff <= '0;
         end
         if (state_ff == sobel_pkg::ST_IDLE && req_valid) begin
            pix_ff <= {req_red_in, req_green_in, req_blue_in};
         end
         if (state_ff == sobel_pkg::ST_READ) begin
            for (int y = 0; y < 3; y++) begin
               win_ff[y][0] <= win_ff[y][1];
               win_ff[y][1] <= win_ff[y][2];
            end
            win_ff[0][2] <= up_rd;
            win_ff[1][2] <= lo_rd;
            win_ff[2][2] <= pix_ff;
            for (int k = 0; k < 4; k++) begin
               var_ff[k] <= vlist[k];
            end
            nres_ff <= vcount;
            idx_ff  <= '0;
            if (col_ff + CW'(1) >= w_eff) begin
               col_ff <= '0;
               row_ff <= (row_ff + 16'd1 >= h_eff) ? 16'd0 : row_ff + 16'd1;
            end else begin
               col_ff <= col_ff + CW'(1);
            end
         end
         if (issue) begin
            pend_ff <= 1'b1;
            pidx_ff <= idx_ff[1:0];
            idx_ff  <= idx_ff + 3'd1;
         end
         if (fin) begin
            pend_ff  <= 1'b0;
            out_v_ff <= 1'b1;
            out_e_ff <= mean;
            out_f_ff <= var_ff[pidx_ff].fend;
            out_l_ff <= (3'(pidx_ff) + 3'd1 == nres_ff);
         end else if (out_v_ff && !rsp_stall) begin
            out_v_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_edge_value = out_e_ff;
   assign rsp_frame_end  = out_f_ff;
   assign rsp_run_last   = out_l_ff;

endmodule

[sv/sobel_ram.sv]
module sobel_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/sobel_mag.sv]
// one channel: sobel sums and squares captured on load, then the integer root
// one bit per cycle; the root tops out at 255, which gives the saturation
module sobel_mag (
   input  logic       clock,
   input  logic       load,
   input  logic [7:0] p00, p01, p02, p10, p12, p20, p21, p22,
   output logic [7:0] mag,
   output logic       ready
);

   logic signed [10:0] gx, gy;
   logic signed [21:0] gx_w, gy_w;
   logic [20:0]        sq_in;
   logic [20:0]        sq_ff;
   logic [7:0]         root_ff, root_in;
   logic [7:0]         bit_ff, bit_in;
   logic [7:0]         t;
   logic [15:0]        tt;

   always_comb begin
      gx = (11'(p02) - 11'(p00)) + ((11'(p12) - 11'(p10)) <<< 1) + (11'(p22) - 11'(p20));
      gy = (11'(p20) + (11'(p21) << 1) + 11'(p22)) - (11'(p00) + (11'(p01) << 1) + 11'(p02));
      gx_w  = 22'(gx);
      gy_w  = 22'(gy);
      sq_in = 21'(gx_w * gx_w) + 21'(gy_w * gy_w);
   end

   // one root bit per cycle, most significant first
   always_comb begin
      t       = root_ff | bit_ff;
      tt      = 16'(t) * 16'(t);
      root_in = root_ff;
      if ({5'd0, tt} <= sq_ff) begin
         root_in = t;
      end
      bit_in = bit_ff >> 1;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sq_ff   <= sq_in;
         root_ff <= '0;
         bit_ff  <= 8'h80;
      end else if (bit_ff != '0) begin
         root_ff <= root_in;
         bit_ff  <= bit_in;
      end
   end

   assign ready = (bit_ff == '0);
   assign mag   = root_ff;

endmodule

[sim/tb_sobel_rgb_edge_magnitude_unit.sv]
module tb_sobel_rgb_edge_magnitude_unit;

   localparam int LINE_DEPTH = 2048;
   localparam int STALL_PCT  = 38;
   localparam int DRAIN_WAIT = 30;
   localparam int QUIET_MAX  = 4000;   // cycles with no handshake before giving up
   localparam int RAND_ITEMS = 80;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_red_in = '0;
   logic [7:0]  req_green_in = '0;
   logic [7:0]  req_blue_in = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_edge_value;
   logic        rsp_frame_end;
   logic        rsp_run_last;
   logic        csr_write = 1'b0;
   logic        csr_index = sobel_pkg::CSR_FRAME_WIDTH;
   logic [sobel_pkg::CSR_W-1:0] csr_data = '0;

   sobel_rgb_edge_magnitude_unit dut (.*);

   always #5 clock = ~clock;

   // one expected result
   typedef struct {
      logic [7:0] edge_value;
      logic       frame_end;
      logic       run_last;
   } edge_result_type;

   // directed stimulus row: new_frame rewrites the geometry before the pixel
   typedef struct {
      bit          new_frame;
      int          wd;
      int          ht;
      logic [7:0]  red, green, blue;
      bit          known;
      logic [7:0]  known_edge;
   } pixel_row_type;

   edge_result_type edge_due[$];

   // predictor state
   logic [23:0] line_up [LINE_DEPTH];
   logic [23:0] line_dn [LINE_DEPTH];
   logic [23:0] pix_win [3][3];
   int unsigned cfg_width, cfg_height, cur_col, cur_row;

   int  miss_count = 0;
   int  results_seen = 0;
   int  requests_sent = 0;
   int  frames_seen = 0;
   int  idle_cycles = 0;
   bit  calm = 1'b0;      // no idling on either side while set

   function automatic logic [7:0] root_sat(int unsigned s);
      int unsigned r, t;
      r = 0;
      if (s >= 65536) return 8'd255;
      for (int b = 128; b != 0; b >>= 1) begin
         t = r | b;
         if (t * t <= s) r = t;
      end
      return r[7:0];
   endfunction

   // rbot: center on bottom row, rtop: mirror top row,
   // cright: center on right column, cleft: mirror left column
   function automatic logic [7:0] window_edge(bit rbot, bit rtop, bit cright, bit cleft);
      int ri[3], ci[3], v[3][3];
      int gx, gy;
      int unsigned acc;
      acc = 0;
      if (rbot) ri = '{1, 2, 1};
      else      ri = '{rtop ? 2 : 0, 1, 2};
      if (cright) ci = '{1, 2, 1};
      else        ci = '{cleft ? 2 : 0, 1, 2};
      for (int ch = 0; ch < 3; ch++) begin
         for (int y = 0; y < 3; y++)
            for (int x = 0; x < 3; x++)
               v[y][x] = (pix_win[ri[y]][ci[x]] >> (16 - 8 * ch)) & 8'hff;
         gx = (v[0][2] - v[0][0]) + 2 * (v[1][2] - v[1][0]) + (v[2][2] - v[2][0]);
         gy = (v[2][0] + 2 * v[2][1] + v[2][2]) - (v[0][0] + 2 * v[0][1] + v[0][2]);
         acc += root_sat(gx * gx + gy * gy);
      end
      return 8'(acc / 3);
   endfunction

   function automatic int unsigned used_width();
      if (cfg_width > LINE_DEPTH) return LINE_DEPTH;
      if (cfg_width < 2) return 2;
      return cfg_width;
   endfunction

   function automatic int unsigned used_height();
      return (cfg_height < 2) ? 2 : cfg_height;
   endfunction

   function automatic void push_edge(logic [7:0] e, bit fe);
      edge_result_type x;
      x.edge_value = e;
      x.frame_end  = fe;
      x.run_last   = 1'b0;
      edge_due.push_back(x);
   endfunction

   // advance the predictor by one accepted pixel, queue its results
   function automatic void predict_pixel(logic [23:0] pix);
      int unsigned w, h, r, c, a, n0;
      bit last_row;
      w = used_width();
      h = used_height();
      r = cur_row;
      c = cur_col;
      a = c % LINE_DEPTH;
      n0 = edge_due.size();
      last_row = (r == h - 1);
      for (int y = 0; y < 3; y++) begin
         pix_win[y][0] = pix_win[y][1];
         pix_win[y][1] = pix_win[y][2];
      end
      pix_win[0][2] = line_up[a];
      pix_win[1][2] = line_dn[a];
      pix_win[2][2] = pix;
      line_up[a] = line_dn[a];
      line_dn[a] = pix;
      if (r >= 1) begin
         if (c >= 1) begin
            push_edge(window_edge(0, r == 1, 0, c == 1), 0);
            if (last_row) push_edge(window_edge(1, 0, 0, c == 1), 0);
         end
         if (c == w - 1) begin
            push_edge(window_edge(0, r == 1, 1, 0), 0);
            if (last_row) push_edge(window_edge(1, 0, 1, 0), 1);
         end
      end
      if (edge_due.size() > n0) edge_due[$].run_last = 1'b1;
      if (c + 1 >= w) begin
         cur_col = 0;
         cur_row = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         cur_col = c + 1;
      end
   endfunction

   task automatic report_miss(string what);
      miss_count++;
      if (miss_count <= 10) $display("mismatch %0d at %0t: %s", miss_count, $time, what);
   endtask

   // result side: random stall, check each accepted result against the oldest expectation
   always @(posedge clock) begin
      edge_result_type x;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (rsp_frame_end) frames_seen++;
         if (edge_due.size() == 0) begin
            report_miss($sformatf("unexpected result edge=%0d frame_end=%0b run_last=%0b",
                                  rsp_edge_value, rsp_frame_end, rsp_run_last));
         end else begin
            x = edge_due.pop_front();
            if (rsp_edge_value !== x.edge_value || rsp_frame_end !== x.frame_end ||
                rsp_run_last !== x.run_last)
               report_miss($sformatf("exp edge=%0d fe=%0b last=%0b, got edge=%0d fe=%0b last=%0b",
                                     x.edge_value, x.frame_end, x.run_last,
                                     rsp_edge_value, rsp_frame_end, rsp_run_last));
         end
      end
      rsp_stall <= calm ? 1'b0 : ($urandom_range(99) < STALL_PCT);
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= QUIET_MAX) begin
         $display("watchdog: no progress for %0d cycles", QUIET_MAX);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // one pixel request; called just after a rising edge, returns just after its acceptance
   task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                             bit known = 0, logic [7:0] known_edge = '0);
      int n0;
      if (!calm && $urandom_range(99) < STALL_PCT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_red_in   <= r;
      req_green_in <= g;
      req_blue_in  <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      n0 = edge_due.size();
      predict_pixel({r, g, b});
      // typed expectation overrides the predicted magnitude
      if (known)
         for (int i = n0; i < edge_due.size(); i++) edge_due[i].edge_value = known_edge;
      requests_sent++;
   endtask

   // geometry write, only once the block has gone quiet
   task automatic set_geometry(int wd, int ht);
      req_valid <= 1'b0;
      wait (edge_due.size() == 0);
      @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= sobel_pkg::CSR_FRAME_WIDTH;
      csr_data  <= wd[sobel_pkg::CSR_W-1:0];
      @(posedge clock);
      cfg_width = wd & 12'hfff;
      cur_col = 0;
      cur_row = 0;
      csr_index <= sobel_pkg::CSR_FRAME_HEIGHT;
      csr_data  <= ht[sobel_pkg::CSR_W-1:0];
      @(posedge clock);
      cfg_height = ht & 16'hffff;
      cur_col = 0;
      cur_row = 0;
      csr_write <= 1'b0;
   endtask

   function automatic logic [7:0] any_channel();
      case ($urandom_range(3))
         0: return 8'h00;
         1: return 8'hff;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   pixel_row_type directed[$];

   initial begin
      int wd, ht, npix;
      logic [7:0] base;
      for (int i = 0; i < LINE_DEPTH; i++) begin
         line_up[i] = '0;
         line_dn[i] = '0;
      end
      pix_win = '{default: '0};
      cfg_width = 640;
      cfg_height = 480;
      cur_col = 0;
      cur_row = 0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset geometry: a few pixels of row 0, which give no results
      for (int i = 0; i < 4; i++) send_pixel(any_channel(), any_channel(), any_channel());

      // directed: flat 2x2 frame gives zero everywhere
      for (int i = 0; i < 4; i++)
         directed.push_back('{i == 0, 2, 2, 8'h5a, 8'h5a, 8'h5a, 1, 8'd0});
      // 2x2 checkerboard of the extremes
      directed.push_back('{1, 2, 2, 8'hff, 8'h00, 8'hff, 0, 0});
      directed.push_back('{0, 2, 2, 8'h00, 8'hff, 8'h00, 0, 0});
      directed.push_back('{0, 2, 2, 8'h00, 8'hff, 8'h00, 0, 0});
      directed.push_back('{0, 2, 2, 8'hff, 8'h00, 8'hff, 0, 0});
      // 4x3 step edge, saturates every channel
      for (int i = 0; i < 12; i++)
         directed.push_back('{i == 0, 4, 3, (i % 4 < 2) ? 8'h00 : 8'hff,
                              (i % 4 < 2) ? 8'h00 : 8'hff, (i % 4 < 2) ? 8'h00 : 8'hff, 0, 0});
      // 3x2 frame with single bits set, one bit per channel in each pixel
      for (int i = 0; i < 6; i++)
         directed.push_back('{i == 0, 3, 2, 8'h01 << i, 8'h80 >> i, 8'h01 << (i + 2), 0, 0});
      foreach (directed[i]) begin
         if (directed[i].new_frame) set_geometry(directed[i].wd, directed[i].ht);
         send_pixel(directed[i].red, directed[i].green, directed[i].blue,
                    directed[i].known, directed[i].known_edge);
      end

      // raw width beyond range clamps to the line depth, height 0 clamps to 2
      set_geometry(4095, 0);
      for (int i = 0; i < 4; i++)
         send_pixel(any_channel(), any_channel(), any_channel());
      // narrowest width, tallest height, partial frame
      set_geometry(0, 65535);
      for (int i = 0; i < 8; i++) send_pixel(any_channel(), any_channel(), any_channel());
      // width and height of one both clamp to 2
      set_geometry(1, 1);
      for (int i = 0; i < 8; i++) send_pixel(any_channel(), any_channel(), any_channel());

      // random frames: mostly whole frames, some cut short or running into the next
      for (int done = 0; done < RAND_ITEMS; ) begin
         wd = ($urandom_range(9) == 0) ? $urandom_range(40, 7) : $urandom_range(6, 2);
         ht = $urandom_range(5, 2);
         set_geometry(wd, ht);
         case ($urandom_range(9))
            0: npix = $urandom_range(wd * ht - 1, 1);
            1: npix = wd * ht + $urandom_range(2 * wd, 1);
            default: npix = wd * ht;
         endcase
         base = 8'($urandom_range(255));
         for (int i = 0; i < npix; i++) begin
            calm = (done >= 30 && done < 60);
            if ($urandom_range(1))
               send_pixel(8'(base + $urandom_range(16)), 8'(base + $urandom_range(16)),
                          8'(base + $urandom_range(16)));
            else
               send_pixel(any_channel(), any_channel(), any_channel());
            done++;
         end
         calm = 1'b0;
      end

      req_valid <= 1'b0;
      wait (edge_due.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("%0d pixel requests, %0d edge results, %0d complete frames; %0d mismatches",
               requests_sent, results_seen, frames_seen, miss_count);
      $display("flat, checkerboard, step and single-bit frames, clamped geometry writes, %s",
               "then random small frames under random stalls");
      if (miss_count == 0 && edge_due.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
